// ===== src/jacobian_residual_scatter_accumulate_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the J-transpose residual accumulator
// ----------------------------------------------------------------------------
`ifndef JACOBIAN_RESIDUAL_SCATTER_ACCUMULATE_CORE_MACROS_SVH
`define JACOBIAN_RESIDUAL_SCATTER_ACCUMULATE_CORE_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define JRSA_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define JRSA_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== src/jrsa_pkg.sv =====
// ----------------------------------------------------------------------------
// jrsa_pkg
// Types and constants shared by the J-transpose residual accumulator.
// ----------------------------------------------------------------------------
package jrsa_pkg;

   localparam int NodeCount   = 4096;
   localparam int NodeWidth   = 12;
   localparam int Components  = 6;
   localparam int CompWidth   = 3;
   localparam int SumWidth    = 48;
   localparam int AddrWidth   = NodeWidth + CompWidth;
   localparam int MemDepth    = 1 << AddrWidth;

   localparam logic [1:0] OpAccumulate = 2'd0;
   localparam logic [1:0] OpRead       = 2'd1;
   localparam logic [1:0] OpClear      = 2'd2;
   localparam logic [1:0] OpUnused     = 2'd3;

   localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
   localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

   typedef struct packed {
      logic [1:0]         op;
      logic [11:0]        node_index;
      logic [15:0]        blend_weight;
      logic signed [31:0] residual_value;
      logic signed [31:0] grad_0;
      logic signed [31:0] grad_1;
      logic signed [31:0] grad_2;
      logic signed [31:0] grad_3;
      logic signed [31:0] grad_4;
      logic signed [31:0] grad_5;
   } req_word_type;

   typedef struct packed {
      logic [11:0]        read_node;
      logic signed [47:0] sum_0;
      logic signed [47:0] sum_1;
      logic signed [47:0] sum_2;
      logic signed [47:0] sum_3;
      logic signed [47:0] sum_4;
      logic signed [47:0] sum_5;
   } rsp_word_type;

   // controller to datapath
   typedef struct packed {
      logic                 load;      // capture request word
      logic                 sweep;     // reset clearing pass write
      logic                 mul_a;     // weight product
      logic                 mul_b;     // residual times grad of current comp
      logic                 mul_c;     // scale
      logic                 rd;        // memory read of current comp
      logic                 wr;        // memory write of current comp
      logic                 wr_zero;   // write zero (clear)
      logic                 cap_sum;   // capture read data into result slot
      logic [CompWidth-1:0] comp;
      logic [NodeWidth-1:0] sweep_node;
   } jrsa_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       node_ok;
   } jrsa_sts_type;

endpackage

// ===== src/jrsa_ram.sv =====
// ----------------------------------------------------------------------------
// jrsa_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module jrsa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/jrsa_datapath.sv =====
// ----------------------------------------------------------------------------
// jrsa_datapath
// Request capture, multiply chain, saturating update and node sum store.
// ----------------------------------------------------------------------------
module jrsa_datapath import jrsa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write,
   input  logic [23:0]  csr_wdata,
   input  req_word_type req_word,
   input  jrsa_cmd_type cmd,
   output jrsa_sts_type sts,
   output rsp_word_type rsp_word
);
   logic [23:0]          tws_ff;
   req_word_type         req_ff;
   logic [23:0]          a_ff;
   logic [46:0]          b_ff;
   logic                 neg_ff;
   logic [47:0]          c_ff;
   logic                 cneg_ff;
   logic [SumWidth-1:0]  sum_ff [Components];

   logic [31:0]          rmag;
   logic [31:0]          gmag;
   logic signed [31:0]   gsel;
   logic [63:0]          rg_prod;
   logic [39:0]          a_prod;
   logic [70:0]          c_prod;
   logic [54:0]          c_shift;
   logic [47:0]          c_in;
   logic signed [SumWidth:0] acc;
   logic signed [SumWidth-1:0] sat_val;
   logic [SumWidth-1:0]  rd_data;
   logic [AddrWidth-1:0] addr;
   logic [SumWidth-1:0]  wr_data;
   logic                 wr_en;
   logic [AddrWidth-1:0] wr_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         tws_ff <= 24'd65536;
      end else if (csr_write) begin
         tws_ff <= csr_wdata;
      end
   end

   always_comb begin
      case (cmd.comp)
         3'd0:    gsel = req_ff.grad_0;
         3'd1:    gsel = req_ff.grad_1;
         3'd2:    gsel = req_ff.grad_2;
         3'd3:    gsel = req_ff.grad_3;
         3'd4:    gsel = req_ff.grad_4;
         default: gsel = req_ff.grad_5;
      endcase
      rmag    = req_ff.residual_value[31] ? 32'(-req_ff.residual_value) : req_ff.residual_value;
      gmag    = gsel[31] ? 32'(-gsel) : gsel;
      rg_prod = 64'(rmag) * 64'(gmag);
      a_prod  = 40'(tws_ff) * 40'(req_ff.blend_weight);
      c_prod  = 71'(a_ff) * 71'(b_ff);
      c_shift = c_prod[70:16];
      c_in    = (c_shift > 55'(48'h8000_0000_0000)) ? 48'h8000_0000_0000 : c_shift[47:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_word;
      end
      if (cmd.mul_a) begin
         a_ff <= a_prod[39:16];
      end
      if (cmd.mul_b) begin
         b_ff   <= rg_prod[62:16];
         neg_ff <= (req_ff.residual_value[31] == gsel[31]);
      end
      if (cmd.mul_c) begin
         c_ff    <= c_in;
         cneg_ff <= neg_ff;
      end
      if (cmd.cap_sum) begin
         sum_ff[cmd.comp] <= sts.node_ok ? rd_data : '0;
      end
   end

   always_comb begin
      acc = cneg_ff ? ($signed({rd_data[47], rd_data}) - $signed({1'b0, c_ff}))
                    : ($signed({rd_data[47], rd_data}) + $signed({1'b0, c_ff}));
      if (acc > $signed({SumMax[47], SumMax})) begin
         sat_val = SumMax;
      end else if (acc < $signed({SumMin[47], SumMin})) begin
         sat_val = SumMin;
      end else begin
         sat_val = acc[47:0];
      end
      addr    = {req_ff.node_index, cmd.comp};
      wr_en   = cmd.wr || cmd.sweep;
      wr_addr = cmd.sweep ? {cmd.sweep_node, cmd.comp} : addr;
      wr_data = (cmd.wr_zero || cmd.sweep) ? '0 : sat_val;
   end

   jrsa_ram #(
      .Width (SumWidth),
      .Depth (MemDepth)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   assign sts.op      = req_ff.op;
   assign sts.node_ok = (32'(req_ff.node_index) < NodeCount);

   assign rsp_word.read_node = req_ff.node_index;
   assign rsp_word.sum_0     = sum_ff[0];
   assign rsp_word.sum_1     = sum_ff[1];
   assign rsp_word.sum_2     = sum_ff[2];
   assign rsp_word.sum_3     = sum_ff[3];
   assign rsp_word.sum_4     = sum_ff[4];
   assign rsp_word.sum_5     = sum_ff[5];
endmodule

// ===== src/jrsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// jrsa_ctrl
// Sequencer: clearing pass, per-component multiply and read-modify-write, clear and read.
// ----------------------------------------------------------------------------
module jrsa_ctrl import jrsa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   input  jrsa_sts_type sts,
   output jrsa_cmd_type cmd
);
   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_DECODE, S_MULB, S_MULC, S_WRITE, S_READ, S_CAP
   } state_type;

   state_type            state_ff, state_in;
   logic [CompWidth-1:0] comp_ff, comp_in;
   logic [NodeWidth-1:0] node_ff, node_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 last_comp;

   assign last_comp = (comp_ff == CompWidth'(Components - 1));
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      node_in      = node_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.comp     = comp_ff;
      cmd.sweep_node = node_ff;
      unique case (state_ff)
         S_SWEEP: begin
            cmd.sweep = 1'b1;
            comp_in   = last_comp ? '0 : comp_ff + 1'b1;
            if (last_comp) begin
               node_in = node_ff + 1'b1;
               if (node_ff == NodeWidth'(NodeCount - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_IDLE: begin
            comp_in = '0;
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.mul_a = 1'b1;
            unique case (sts.op)
               OpAccumulate: state_in = sts.node_ok ? S_MULB : S_IDLE;
               OpRead:       state_in = S_READ;
               OpClear:      state_in = sts.node_ok ? S_WRITE : S_IDLE;
               default:      state_in = S_IDLE;
            endcase
         end
         S_MULB: begin
            cmd.mul_b = 1'b1;
            state_in  = S_MULC;
         end
         S_MULC: begin
            cmd.mul_c = 1'b1;
            cmd.rd    = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            cmd.wr      = 1'b1;
            cmd.wr_zero = (sts.op == OpClear);
            comp_in     = comp_ff + 1'b1;
            if (last_comp) begin
               state_in = S_IDLE;
            end else if (sts.op != OpClear) begin
               state_in = S_MULB;
            end
         end
         S_READ: begin
            cmd.rd   = 1'b1;
            state_in = S_CAP;
         end
         S_CAP: begin
            cmd.cap_sum = 1'b1;
            comp_in     = comp_ff + 1'b1;
            if (last_comp) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         comp_ff      <= '0;
         node_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         node_ff      <= node_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

// ===== src/jacobian_residual_scatter_accumulate_core.sv =====
// ----------------------------------------------------------------------------
// jacobian_residual_scatter_accumulate_core
// Scatters -w*blend*residual*grad into six saturating 48-bit sums per node.
// ----------------------------------------------------------------------------
//  channel   direction   word type       handshake
//  req_      in          req_word_type   req_valid / req_stall
//  rsp_      out         rsp_word_type   rsp_valid / rsp_stall
//  csr_      in          24-bit weight   csr_write
//
//  Every request is loaded and then decoded before its components are processed.
//  Components run one at a time: multiply, read and write for accumulate,
//  read and capture for read, one write for clear.
//  After reset a clearing pass over all 4096 nodes x 6 components runs first.
//  A pending result holds req_stall until it is taken.
module jacobian_residual_scatter_accumulate_core import jrsa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [23:0]  csr_wdata
);
`include "jacobian_residual_scatter_accumulate_core_macros.svh"

   jrsa_cmd_type cmd;
   jrsa_sts_type sts;

   jrsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   jrsa_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .req_word  (req_word),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_word  (rsp_word)
   );

   `JRSA_ASSERT_IMP(a_rsp_holds, clock, reset, rsp_valid, req_stall, "rsp pending, req open")
   `JRSA_ASSERT_IMP(a_sweep_excl, clock, reset, cmd.sweep, !cmd.wr && !cmd.rd, "sweep overlap")
   `JRSA_ASSERT_NEXT(a_load_stalls, clock, reset, cmd.load, req_stall, "no stall after word load")
endmodule
